// ----- rtl/least_loaded_class_assigner_assert.svh -----
// Assertion macros shared by the class assigner RTL.
`ifndef LEAST_LOADED_CLASS_ASSIGNER_ASSERT_SVH
`define LEAST_LOADED_CLASS_ASSIGNER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LLCA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LLCA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/llca_pkg.sv -----
// Shared types, constants and helpers for the least loaded class assigner.
`timescale 1ns / 1ps

package llca_pkg;

  // Store geometry.
  localparam int MAX_CLASSES = 256;
  localparam int IDX_W       = $clog2(MAX_CLASSES);
  localparam int WIN_W       = IDX_W + 1;
  localparam int COUNT_BITS  = 16;

  // Field widths.
  localparam int CLASS_W     = 16;
  localparam int SPAN_W      = CLASS_W + 1;
  localparam int CCOUNT_W    = 9;
  localparam int KEY_W       = 64;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 1'b1;

  // Item functions.
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 2'd0,
    FN_ASSIGN = 2'd1,
    FN_CLEAR  = 2'd2
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STS_NEW_LEAST    = 3'd0,
    STS_REUSED       = 3'd1,
    STS_COUNTED      = 3'd2,
    STS_OUT_OF_RANGE = 3'd3,
    STS_CLEARED      = 3'd4
  } status_e;

  // Request from the sequencer to the count store.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    count_t           wr_data;
    logic             clr;
  } store_req_t;

  // Saturating increment of a user count.
  function automatic count_t sat_inc(count_t c);
    return (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

endpackage

// ----- rtl/llca_count_store.sv -----
// Per-class user count memory with valid bits and a registered read.
`timescale 1ns / 1ps

module llca_count_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  llca_pkg::store_req_t req_i,
  output llca_pkg::count_t    rd_data_o
);

  llca_pkg::count_t                     mem [llca_pkg::MAX_CLASSES];
  logic [llca_pkg::MAX_CLASSES-1:0]     vld_q;
  llca_pkg::count_t                     mem_rd_q;
  logic                                 rd_vld_q;

  // Memory write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      mem_rd_q <= mem[req_i.rd_addr];
    end
  end

  // Valid bits: a clear drops them all at once, a write marks its entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // An entry never written since the last clear reads as zero.
  assign rd_data_o = rd_vld_q ? mem_rd_q : '0;

endmodule

// ----- rtl/least_loaded_class_assigner.sv -----
// Top level of the least loaded class assigner: sequencer, registers, output stage.
`timescale 1ns / 1ps
//
// Usage
// -----
// Input beats (func_i, class_in_i, user_key_i) are taken when in_valid_i is
// high and in_stall_o is low. Each load, assign or clear beat gives one output
// beat (class_out_o, status_o), taken when out_valid_o is high and out_stall_i
// is low. A beat with the unused function code gives no output.
// Items are worked one at a time. A load reads its count and writes it back
// (S_LD_BUMP); a clear, a repeat of the previous user or an out-of-range load
// goes straight to S_DONE; a new assign reads every count of the window, one per
// cycle, then bumps the least (S_BUMP); S_DONE waits for a free output register.
// The two configuration registers (class base, class count) are written over
// cfg_valid_i / cfg_ready_o; the sender must do so only while the block is idle,
// which the block itself does not enforce; cfg_ready_o is always high.
// After reset all counts are zero, no previous user is held, the class base
// is 0 and the class count is 256. The count memory is cleared through per
// entry valid bits, so no clearing pass is needed.
// A finished result sits in the output register while a stalled receiver
// holds it; the next item is still accepted and worked, and waits for the
// output register before its own result is shown.

`include "least_loaded_class_assigner_assert.svh"

module least_loaded_class_assigner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [llca_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [llca_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input item channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [llca_pkg::FUNC_W-1:0]       func_i,
  input  logic [llca_pkg::CLASS_W-1:0]      class_in_i,
  input  logic [llca_pkg::KEY_W-1:0]        user_key_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [llca_pkg::CLASS_W-1:0]      class_out_o,
  output logic [llca_pkg::STATUS_W-1:0]     status_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_BUMP,
    S_SCAN,
    S_BUMP,
    S_DONE
  } state_e;

  state_e                              state_q;
  logic [llca_pkg::CLASS_W-1:0]        class_base_q;
  logic [llca_pkg::CCOUNT_W-1:0]       class_count_q;

  logic [llca_pkg::WIN_W-1:0]          iss_q;
  logic                                rd_pend_q;
  logic [llca_pkg::IDX_W-1:0]          rd_idx_q;
  logic                                rd_last_q;
  llca_pkg::count_t                    best_cnt_q;
  logic [llca_pkg::IDX_W-1:0]          best_idx_q;
  logic [llca_pkg::IDX_W-1:0]          idx_q;
  logic [llca_pkg::KEY_W-1:0]          key_q;

  logic [llca_pkg::KEY_W-1:0]          prev_key_q;
  logic [llca_pkg::CLASS_W-1:0]        prev_class_q;
  logic                                have_prev_q;

  logic [llca_pkg::CLASS_W-1:0]        res_class_q;
  llca_pkg::status_e                   res_status_q;
  logic                                out_valid_q;
  logic [llca_pkg::CLASS_W-1:0]        class_out_q;
  llca_pkg::status_e                   status_q;

  logic [llca_pkg::SPAN_W-1:0]         cnt_span;
  logic [llca_pkg::SPAN_W-1:0]         room_span;
  logic [llca_pkg::SPAN_W-1:0]         win_span;
  logic [llca_pkg::WIN_W-1:0]          win_n;
  logic [llca_pkg::CLASS_W-1:0]        diff;
  logic                                in_rng;
  logic                                in_acc;
  logic                                out_free;
  logic                                out_load;
  logic                                key_hit;
  logic [llca_pkg::CLASS_W-1:0]        new_class;
  llca_pkg::func_e                     func;
  llca_pkg::store_req_t                req;
  llca_pkg::count_t                    rd_data;

  // Window size: zero acts as one, capped by the store depth and the id space.
  always_comb begin
    cnt_span  = llca_pkg::SPAN_W'(class_count_q);
    room_span = llca_pkg::SPAN_W'(1 << llca_pkg::CLASS_W) -
                llca_pkg::SPAN_W'(class_base_q);
    if (cnt_span == '0) begin
      cnt_span = llca_pkg::SPAN_W'(1);
    end
    if (cnt_span > llca_pkg::SPAN_W'(llca_pkg::MAX_CLASSES)) begin
      cnt_span = llca_pkg::SPAN_W'(llca_pkg::MAX_CLASSES);
    end
    win_span = (cnt_span > room_span) ? room_span : cnt_span;
    win_n    = win_span[llca_pkg::WIN_W-1:0];
  end

  // Input decode and handshake.
  assign func       = llca_pkg::func_e'(func_i);
  assign diff       = class_in_i - class_base_q;
  assign in_rng     = (class_in_i >= class_base_q) &&
                      (llca_pkg::SPAN_W'(diff) < win_span);
  assign key_hit    = have_prev_q && (user_key_i == prev_key_q);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;
  assign new_class  = class_base_q + llca_pkg::CLASS_W'(best_idx_q);

  // Count store requests for each step of the sequencer.
  always_comb begin
    req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (func == llca_pkg::FN_LOAD) && in_rng) begin
          req.rd_en   = 1'b1;
          req.rd_addr = diff[llca_pkg::IDX_W-1:0];
        end
        if (in_acc && (func == llca_pkg::FN_CLEAR)) begin
          req.clr = 1'b1;
        end
      end
      S_SCAN: begin
        req.rd_en   = (iss_q < win_n);
        req.rd_addr = iss_q[llca_pkg::IDX_W-1:0];
      end
      S_LD_BUMP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_q;
        req.wr_data = llca_pkg::sat_inc(rd_data);
      end
      S_BUMP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = best_idx_q;
        req.wr_data = llca_pkg::sat_inc(best_cnt_q);
      end
      S_DONE: begin
        req = '0;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  llca_count_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rd_data_o(rd_data)
  );

  // Configuration registers; the sender must write them only while the block is idle (the block does not enforce this).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_base_q  <= '0;
      class_count_q <= llca_pkg::CCOUNT_W'(llca_pkg::MAX_CLASSES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        llca_pkg::CFG_CLASS_BASE:  class_base_q  <= cfg_data_i;
        llca_pkg::CFG_CLASS_COUNT: class_count_q <= cfg_data_i[llca_pkg::CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, previous-user registers and output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      iss_q        <= '0;
      rd_pend_q    <= 1'b0;
      rd_idx_q     <= '0;
      rd_last_q    <= 1'b0;
      best_cnt_q   <= '0;
      best_idx_q   <= '0;
      idx_q        <= '0;
      key_q        <= '0;
      prev_key_q   <= '0;
      prev_class_q <= '0;
      have_prev_q  <= 1'b0;
      res_class_q  <= '0;
      res_status_q <= llca_pkg::STS_NEW_LEAST;
      out_valid_q  <= 1'b0;
      class_out_q  <= '0;
      status_q     <= llca_pkg::STS_NEW_LEAST;
    end else begin
      // Read tracking: data comes back in the cycle after the request.
      rd_pend_q <= req.rd_en;
      rd_idx_q  <= req.rd_addr;
      rd_last_q <= req.rd_en && (state_q == S_SCAN) &&
                   (iss_q == win_n - llca_pkg::WIN_W'(1));

      // Output valid: set by a finished result, dropped once the beat is taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (func)
              llca_pkg::FN_LOAD: begin
                if (in_rng) begin
                  idx_q        <= diff[llca_pkg::IDX_W-1:0];
                  res_class_q  <= class_in_i;
                  res_status_q <= llca_pkg::STS_COUNTED;
                  state_q      <= S_LD_BUMP;
                end else begin
                  res_class_q  <= '0;
                  res_status_q <= llca_pkg::STS_OUT_OF_RANGE;
                  state_q      <= S_DONE;
                end
              end
              llca_pkg::FN_ASSIGN: begin
                if (key_hit) begin
                  res_class_q  <= prev_class_q;
                  res_status_q <= llca_pkg::STS_REUSED;
                  state_q      <= S_DONE;
                end else begin
                  key_q   <= user_key_i;
                  iss_q   <= '0;
                  state_q <= S_SCAN;
                end
              end
              llca_pkg::FN_CLEAR: begin
                have_prev_q  <= 1'b0;
                prev_key_q   <= '0;
                prev_class_q <= '0;
                res_class_q  <= '0;
                res_status_q <= llca_pkg::STS_CLEARED;
                state_q      <= S_DONE;
              end
              default: begin
                // Unused function: no state change and no result.
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (req.rd_en) begin
            iss_q <= iss_q + llca_pkg::WIN_W'(1);
          end
          // Keep the first minimum: a later equal count does not win.
          if (rd_pend_q) begin
            if ((rd_idx_q == '0) || (rd_data < best_cnt_q)) begin
              best_cnt_q <= rd_data;
              best_idx_q <= rd_idx_q;
            end
            if (rd_last_q) begin
              state_q <= S_BUMP;
            end
          end
        end
        S_LD_BUMP: begin
          state_q <= S_DONE;
        end
        S_BUMP: begin
          prev_key_q   <= key_q;
          prev_class_q <= new_class;
          have_prev_q  <= 1'b1;
          res_class_q  <= new_class;
          res_status_q <= llca_pkg::STS_NEW_LEAST;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            class_out_q <= res_class_q;
            status_q    <= res_status_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign class_out_o = class_out_q;
  assign status_o    = status_q;

  // Returned read data is only expected while a load or a scan waits for it.
  `LLCA_ASSERT_SAME(a_rd_pend_state, clk_i, rst_ni, rd_pend_q, (state_q == S_SCAN) || (state_q == S_LD_BUMP), "read data returned outside a load or scan")
  // The chosen class always lies inside the current window.
  `LLCA_ASSERT_SAME(a_best_in_window, clk_i, rst_ni, state_q == S_BUMP, ({1'b0, best_idx_q} < win_n), "least used class outside the window")
  // An accepted clear reports cleared next and forgets the previous user.
  `LLCA_ASSERT_NEXT(a_clear_result, clk_i, rst_ni, in_acc && (func == llca_pkg::FN_CLEAR), (state_q == S_DONE) && (res_status_q == llca_pkg::STS_CLEARED) && !have_prev_q, "clear did not reset the previous user")

endmodule
